### hw/rtl/segment_allocator_fit_policies_top_macros.svh
// assertion macros for the segment allocator
// used by segment_allocator_fit_policies_top
`ifndef SEGMENT_ALLOCATOR_FIT_POLICIES_TOP_MACROS_SVH
`define SEGMENT_ALLOCATOR_FIT_POLICIES_TOP_MACROS_SVH
`ifndef SYNTH
`define SAFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAFP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/safp_pkg.sv
// shared types and constants for the segment allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package safp_pkg;
    localparam int MAX_SEGMENTS_D  = 64;
    localparam int MAX_RECORDS_D   = 63;
    localparam int MEM_UNITS_MAX_D = 1024;
    localparam int TOTAL_RESET     = 100;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;

    localparam logic [1:0] POL_BEST  = 2'd0;
    localparam logic [1:0] POL_WORST = 2'd1;
    localparam logic [1:0] POL_NEXT  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_NOREC   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADSIZE = 3'd4;

    localparam logic ADDR_FIT   = 1'b0;
    localparam logic ADDR_TOTAL = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] request_size;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] block_start;
        logic [6:0] free_segments;
    } out_word_t;

    // datapath operations driven by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_SEG_RD,
        OP_SEG_WR,
        OP_REC_RD,
        OP_REC_WR,
        OP_LATCH_PICK,
        OP_LATCH_AUX,
        OP_LATCH_REC
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [10:0] addr;
        logic [9:0]  wr_start;
        logic [10:0] wr_len;
    } dp_cmd_t;

    typedef struct packed {
        logic [9:0]  rd_start;
        logic [10:0] rd_len;
        logic [9:0]  pick_start;
        logic [10:0] pick_len;
        logic [9:0]  aux_start;
        logic [10:0] aux_len;
        logic [9:0]  rec_start;
    } dp_stat_t;
endpackage
`default_nettype wire

### hw/rtl/segment_allocator_fit_policies_top.sv
// top level of the segment allocator: apb registers, controller, datapath
// depends on safp_pkg, safp_ctrl, safp_datapath and the macros header
//
// usage
//   input channel: in_valid / in_stall carry one word {kind, request_size}
//   output channel: out_valid / out_stall carry one word per input word
//   {status, block_start, free_segments}
//   config: apb port, fit_policy at 0x0 and total_units at 0x4
// work per word
//   allocate: segments are read in turn, a used-up segment is shifted out
//   and the new record is pushed; free: records are searched, segments
//   walked to the position, records shifted, then a merge or an insert
//   init: one segment write; rejected and unused-kind words go to the result
//   the single-port segment memory, read one entry at a time, sets the rate
// one word is worked on at a time; in_stall is high while busy
// reset: the block writes one segment spanning total_units (clamped to 1..MEM_UNITS_MAX), then idles
// a stalled result holds in the output register; the next word is taken
// in but its result waits until the output register frees up
`timescale 1ns / 1ps
`default_nettype none
`include "segment_allocator_fit_policies_top_macros.svh"
module segment_allocator_fit_policies_top #(
    parameter int MAX_SEGMENTS  = safp_pkg::MAX_SEGMENTS_D,
    parameter int MAX_RECORDS   = safp_pkg::MAX_RECORDS_D,
    parameter int MEM_UNITS_MAX = safp_pkg::MEM_UNITS_MAX_D
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire safp_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output safp_pkg::out_word_t     out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import safp_pkg::*;

    logic [1:0]  fit_reg;
    logic [10:0] total_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg   <= POL_BEST;
            total_reg <= 11'(TOTAL_RESET);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                ADDR_FIT:   fit_reg   <= pwdata[1:0];
                ADDR_TOTAL: total_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_TOTAL) ? {21'd0, total_reg} : {30'd0, fit_reg};

    safp_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_RECORDS  (MAX_RECORDS),
        .MEM_UNITS_MAX(MEM_UNITS_MAX)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_data),
        .fit_policy (fit_reg),
        .total_units(total_reg),
        .cmd        (cmd),
        .stat       (stat)
    );

    safp_datapath #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .clk (clk),
        .cmd (cmd),
        .stat(stat)
    );

    // a result word reports a segment count within the table size
    `SAFP_ASSERT_IMPL(a_seg_range, clk, rst_n, out_valid, out_data.free_segments <= 7'(MAX_SEGMENTS))
    // failures report block start zero
    `SAFP_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.block_start == 10'd0)
    // accepting a word makes the block busy next cycle
    `SAFP_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule
`default_nettype wire

### hw/rtl/safp_datapath.sv
// segment and record memories with read registers and latches
// depends on safp_pkg
`timescale 1ns / 1ps
`default_nettype none
module safp_datapath #(
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_RECORDS  = 63
) (
    input  wire logic             clk,
    input  wire safp_pkg::dp_cmd_t cmd,
    output safp_pkg::dp_stat_t    stat
);
    import safp_pkg::*;
    localparam int SW = $clog2(MAX_SEGMENTS);
    localparam int RW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    logic [9:0]  seg_s_mem [MAX_SEGMENTS];
    logic [10:0] seg_l_mem [MAX_SEGMENTS];
    logic [9:0]  rec_s_mem [MAX_RECORDS];
    logic [10:0] rec_l_mem [MAX_RECORDS];
    logic [9:0]  rd_s_reg, pk_s_reg, ax_s_reg, rc_s_reg;
    logic [10:0] rd_l_reg, pk_l_reg, ax_l_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SEG_WR:
            begin
                seg_s_mem[cmd.addr[SW-1:0]] <= cmd.wr_start;
                seg_l_mem[cmd.addr[SW-1:0]] <= cmd.wr_len;
            end
            OP_REC_WR:
            begin
                rec_s_mem[cmd.addr[RW-1:0]] <= cmd.wr_start;
                rec_l_mem[cmd.addr[RW-1:0]] <= cmd.wr_len;
            end
            OP_SEG_RD:
            begin
                rd_s_reg <= seg_s_mem[cmd.addr[SW-1:0]];
                rd_l_reg <= seg_l_mem[cmd.addr[SW-1:0]];
            end
            OP_REC_RD:
            begin
                rd_s_reg <= rec_s_mem[cmd.addr[RW-1:0]];
                rd_l_reg <= rec_l_mem[cmd.addr[RW-1:0]];
            end
            OP_LATCH_PICK:
            begin
                pk_s_reg <= rd_s_reg;
                pk_l_reg <= rd_l_reg;
            end
            OP_LATCH_AUX:
            begin
                ax_s_reg <= rd_s_reg;
                ax_l_reg <= rd_l_reg;
            end
            OP_LATCH_REC: rc_s_reg <= rd_s_reg;
            default: ;
        endcase
    end

    assign stat.rd_start   = rd_s_reg;
    assign stat.rd_len     = rd_l_reg;
    assign stat.pick_start = pk_s_reg;
    assign stat.pick_len   = pk_l_reg;
    assign stat.aux_start  = ax_s_reg;
    assign stat.aux_len    = ax_l_reg;
    assign stat.rec_start  = rc_s_reg;
endmodule
`default_nettype wire

### hw/rtl/safp_ctrl.sv
// sequencer for allocate, free and init words
// depends on safp_pkg
`timescale 1ns / 1ps
`default_nettype none
module safp_ctrl #(
    parameter int MAX_SEGMENTS  = 64,
    parameter int MAX_RECORDS   = 63,
    parameter int MEM_UNITS_MAX = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire safp_pkg::in_word_t in_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output safp_pkg::out_word_t     out_word,
    input  wire logic [1:0]         fit_policy,
    input  wire logic [10:0]        total_units,
    output safp_pkg::dp_cmd_t       cmd,
    input  wire safp_pkg::dp_stat_t stat
);
    import safp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK, S_ALLOC_UPD,
        S_REM_RD, S_REM_WAIT, S_REM_WR, S_RSRCH_RD, S_RSRCH_WAIT, S_RSRCH_CHK,
        S_POS_RD, S_POS_WAIT, S_POS_CHK, S_PREV_RD, S_PREV_WAIT, S_PREV_LAT,
        S_DECIDE, S_RSH_RD, S_RSH_WAIT, S_RSH_WR, S_MERGE, S_INS_RD,
        S_INS_WAIT, S_INS_WR, S_DONE
    } state_t;

    state_t      state_reg;
    logic        boot_reg;
    logic [1:0]  kind_reg;
    logic [10:0] size_reg;
    logic [10:0] seg_cnt_reg, rec_cnt_reg;
    logic [10:0] rover_reg;
    logic        rover_v_reg;
    logic [10:0] k_reg, from_reg, pick_reg, rec_idx_reg, p_reg;
    logic        found_reg, jp_reg, jn_reg;
    logic [2:0]  st_reg;
    logic [9:0]  where_reg;
    logic        out_v_reg;
    out_word_t   out_reg;

    logic [10:0] idx_c, tot_c;
    logic        better_c;

    // circular index for next fit scanning, clamped total and the fit comparison
    always_comb
    begin
        idx_c = from_reg + k_reg;
        if (idx_c >= seg_cnt_reg)
            idx_c = idx_c - seg_cnt_reg;
        tot_c = total_units;
        if (tot_c == 11'd0)
            tot_c = 11'd1;
        if (tot_c > 11'(MEM_UNITS_MAX))
            tot_c = 11'(MEM_UNITS_MAX);
        better_c = (fit_policy == POL_WORST) ? (stat.rd_len > stat.pick_len)
                                             : (stat.rd_len < stat.pick_len);
    end

    always_comb
    begin
        cmd = '0;
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_SEG_WR;
                cmd.wr_len = tot_c;
            end
            S_SCAN_RD:
            begin
                cmd.op = OP_SEG_RD;
                cmd.addr = (fit_policy == POL_NEXT) ? idx_c : k_reg;
            end
            S_SCAN_CHK:
                if (stat.rd_len >= size_reg && (!found_reg || better_c))
                    cmd.op = OP_LATCH_PICK;
            S_ALLOC_UPD:
            begin
                cmd.op = OP_SEG_WR;
                cmd.addr = pick_reg;
                cmd.wr_start = stat.pick_start + size_reg[9:0];
                cmd.wr_len = stat.pick_len - size_reg;
            end
            S_REM_RD:
            begin
                cmd.op = OP_SEG_RD;
                cmd.addr = k_reg + 11'd1;
            end
            S_REM_WR:
            begin
                cmd.op = OP_SEG_WR;
                cmd.addr = k_reg;
                cmd.wr_start = stat.rd_start;
                cmd.wr_len = stat.rd_len;
            end
            S_RSRCH_RD:
            begin
                cmd.op = OP_REC_RD;
                cmd.addr = k_reg - 11'd1;
            end
            S_RSRCH_CHK:
                if (stat.rd_len == size_reg)
                    cmd.op = OP_LATCH_REC;
            S_POS_RD:
            begin
                cmd.op = OP_SEG_RD;
                cmd.addr = p_reg;
            end
            S_POS_CHK:
                if (stat.rd_start >= stat.rec_start)
                    cmd.op = OP_LATCH_PICK;
            S_PREV_RD:
            begin
                cmd.op = OP_SEG_RD;
                cmd.addr = p_reg - 11'd1;
            end
            S_PREV_LAT: cmd.op = OP_LATCH_AUX;
            S_RSH_RD:
            begin
                cmd.op = OP_REC_RD;
                cmd.addr = k_reg + 11'd1;
            end
            S_RSH_WR:
            begin
                cmd.op = OP_REC_WR;
                if (kind_reg == KIND_ALLOC)
                begin
                    // push the new record on top of the stack
                    cmd.addr = rec_idx_reg;
                    cmd.wr_start = stat.pick_start;
                    cmd.wr_len = size_reg;
                end
                else
                begin
                    cmd.addr = k_reg;
                    cmd.wr_start = stat.rd_start;
                    cmd.wr_len = stat.rd_len;
                end
            end
            S_MERGE:
            begin
                if (jp_reg)
                begin
                    cmd.op = OP_SEG_WR;
                    cmd.addr = p_reg - 11'd1;
                    cmd.wr_start = stat.aux_start;
                    cmd.wr_len = stat.aux_len + size_reg
                               + (jn_reg ? stat.pick_len : 11'd0);
                end
                else if (jn_reg)
                begin
                    cmd.op = OP_SEG_WR;
                    cmd.addr = p_reg;
                    cmd.wr_start = stat.rec_start;
                    cmd.wr_len = stat.pick_len + size_reg;
                end
            end
            S_INS_RD:
            begin
                if (k_reg <= p_reg)
                begin
                    // shifting done, the freed block goes in at p
                    cmd.op = OP_SEG_WR;
                    cmd.addr = p_reg;
                    cmd.wr_start = stat.rec_start;
                    cmd.wr_len = size_reg;
                end
                else
                begin
                    cmd.op = OP_SEG_RD;
                    cmd.addr = k_reg - 11'd1;
                end
            end
            S_INS_WR:
            begin
                cmd.op = OP_SEG_WR;
                cmd.addr = k_reg;
                cmd.wr_start = stat.rd_start;
                cmd.wr_len = stat.rd_len;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            boot_reg    <= 1'b1;
            kind_reg    <= KIND_INIT;
            size_reg    <= '0;
            seg_cnt_reg <= '0;
            rec_cnt_reg <= '0;
            rover_reg   <= '0;
            rover_v_reg <= 1'b1;
            k_reg <= '0; from_reg <= '0; pick_reg <= '0;
            rec_idx_reg <= '0; p_reg <= '0;
            found_reg <= 1'b0; jp_reg <= 1'b0; jn_reg <= 1'b0;
            st_reg <= ST_OK; where_reg <= '0;
            out_v_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (out_v_reg && !out_stall && state_reg != S_DONE)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        kind_reg <= in_word.kind;
                        size_reg <= in_word.request_size;
                        st_reg <= ST_OK;
                        where_reg <= '0;
                        found_reg <= 1'b0;
                        k_reg <= '0;
                        from_reg <= (rover_v_reg && rover_reg < seg_cnt_reg)
                                    ? rover_reg : 11'd0;
                        if (in_word.kind == KIND_INIT)
                            state_reg <= S_INIT;
                        else if (in_word.kind == 2'd3)
                            state_reg <= S_DONE;
                        else if (in_word.request_size == 11'd0 ||
                                 in_word.request_size > 11'(MEM_UNITS_MAX))
                        begin
                            st_reg <= ST_BADSIZE;
                            state_reg <= S_DONE;
                        end
                        else if (in_word.kind == KIND_ALLOC)
                        begin
                            if (rec_cnt_reg >= 11'(MAX_RECORDS))
                            begin
                                st_reg <= ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else if (seg_cnt_reg == 11'd0)
                            begin
                                st_reg <= ST_NOFIT;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_SCAN_RD;
                        end
                        else
                        begin
                            k_reg <= rec_cnt_reg;
                            state_reg <= (rec_cnt_reg == 11'd0) ? S_DONE : S_RSRCH_RD;
                            if (rec_cnt_reg == 11'd0)
                                st_reg <= ST_NOREC;
                        end
                    end
                S_INIT:
                begin
                    seg_cnt_reg <= 11'd1;
                    rec_cnt_reg <= '0;
                    rover_reg <= '0;
                    rover_v_reg <= 1'b1;
                    // the init after reset gives no result word
                    boot_reg <= 1'b0;
                    state_reg <= boot_reg ? S_IDLE : S_DONE;
                    st_reg <= ST_OK;
                    where_reg <= '0;
                end
                S_SCAN_RD: state_reg <= S_SCAN_WAIT;
                S_SCAN_WAIT: state_reg <= S_SCAN_CHK;
                S_SCAN_CHK:
                begin
                    if (stat.rd_len >= size_reg && (!found_reg || better_c))
                    begin
                        found_reg <= 1'b1;
                        pick_reg <= (fit_policy == POL_NEXT) ? idx_c : k_reg;
                    end
                    if ((fit_policy == POL_NEXT && stat.rd_len >= size_reg) ||
                        k_reg + 11'd1 >= seg_cnt_reg)
                    begin
                        if (!found_reg && stat.rd_len < size_reg)
                        begin
                            st_reg <= ST_NOFIT;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_ALLOC_UPD;
                    end
                    else
                    begin
                        k_reg <= k_reg + 11'd1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_ALLOC_UPD:
                begin
                    logic       rv;
                    logic [10:0] ri;
                    where_reg <= stat.pick_start;
                    rv = rover_v_reg;
                    ri = rover_reg;
                    if (fit_policy == POL_NEXT)
                    begin
                        rv = (pick_reg + 11'd1 < seg_cnt_reg);
                        ri = rv ? pick_reg + 11'd1 : 11'd0;
                    end
                    rec_idx_reg <= rec_cnt_reg;
                    if (stat.pick_len == size_reg)
                    begin
                        if (rv)
                        begin
                            if (ri == pick_reg)
                            begin
                                ri = 11'd0;
                                rv = (seg_cnt_reg > 11'd1);
                            end
                            else if (ri > pick_reg)
                                ri = ri - 11'd1;
                        end
                        k_reg <= pick_reg;
                        state_reg <= S_REM_RD;
                    end
                    else
                        state_reg <= S_RSH_WR;
                    rover_v_reg <= rv;
                    rover_reg <= ri;
                end
                S_REM_RD:
                    if (k_reg + 11'd1 >= seg_cnt_reg)
                    begin
                        seg_cnt_reg <= seg_cnt_reg - 11'd1;
                        state_reg <= (kind_reg == KIND_ALLOC) ? S_RSH_WR : S_DONE;
                    end
                    else
                        state_reg <= S_REM_WAIT;
                S_REM_WAIT: state_reg <= S_REM_WR;
                S_REM_WR:
                begin
                    k_reg <= k_reg + 11'd1;
                    state_reg <= S_REM_RD;
                end
                S_RSRCH_RD: state_reg <= S_RSRCH_WAIT;
                S_RSRCH_WAIT: state_reg <= S_RSRCH_CHK;
                S_RSRCH_CHK:
                    if (stat.rd_len == size_reg)
                    begin
                        rec_idx_reg <= k_reg - 11'd1;
                        p_reg <= '0;
                        state_reg <= S_POS_RD;
                    end
                    else if (k_reg == 11'd1)
                    begin
                        st_reg <= ST_NOREC;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        k_reg <= k_reg - 11'd1;
                        state_reg <= S_RSRCH_RD;
                    end
                S_POS_RD:
                    if (p_reg >= seg_cnt_reg)
                        state_reg <= (p_reg == 11'd0) ? S_DECIDE : S_PREV_RD;
                    else
                        state_reg <= S_POS_WAIT;
                S_POS_WAIT: state_reg <= S_POS_CHK;
                S_POS_CHK:
                    if (stat.rd_start >= stat.rec_start)
                        state_reg <= (p_reg == 11'd0) ? S_DECIDE : S_PREV_RD;
                    else
                    begin
                        p_reg <= p_reg + 11'd1;
                        state_reg <= S_POS_RD;
                    end
                S_PREV_RD: state_reg <= S_PREV_WAIT;
                S_PREV_WAIT: state_reg <= S_PREV_LAT;
                S_PREV_LAT: state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    logic jp, jn;
                    jp = (p_reg != 11'd0) &&
                         ({1'b0, stat.aux_start} + stat.aux_len == {1'b0, stat.rec_start});
                    jn = (p_reg < seg_cnt_reg) &&
                         ({1'b0, stat.rec_start} + size_reg == {1'b0, stat.pick_start});
                    jp_reg <= jp;
                    jn_reg <= jn;
                    if (!jp && !jn && seg_cnt_reg >= 11'(MAX_SEGMENTS))
                    begin
                        st_reg <= ST_FULL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        where_reg <= stat.rec_start;
                        k_reg <= rec_idx_reg;
                        state_reg <= S_RSH_RD;
                    end
                end
                S_RSH_RD:
                    if (kind_reg == KIND_ALLOC)
                    begin
                        rec_cnt_reg <= rec_cnt_reg + 11'd1;
                        state_reg <= S_DONE;
                    end
                    else if (k_reg + 11'd1 >= rec_cnt_reg)
                    begin
                        rec_cnt_reg <= rec_cnt_reg - 11'd1;
                        state_reg <= S_MERGE;
                    end
                    else
                        state_reg <= S_RSH_WAIT;
                S_RSH_WAIT: state_reg <= S_RSH_WR;
                S_RSH_WR:
                begin
                    if (kind_reg == KIND_ALLOC)
                        state_reg <= S_RSH_RD;
                    else
                    begin
                        k_reg <= k_reg + 11'd1;
                        state_reg <= S_RSH_RD;
                    end
                end
                S_MERGE:
                begin
                    if (jp_reg && jn_reg)
                    begin
                        if (rover_v_reg && rover_reg >= p_reg)
                            rover_reg <= rover_reg - 11'd1;
                        k_reg <= p_reg;
                        state_reg <= S_REM_RD;
                    end
                    else if (jp_reg || jn_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        if (rover_v_reg && rover_reg >= p_reg)
                            rover_reg <= rover_reg + 11'd1;
                        k_reg <= seg_cnt_reg;
                        state_reg <= S_INS_RD;
                    end
                end
                S_INS_RD:
                    if (k_reg <= p_reg)
                    begin
                        seg_cnt_reg <= seg_cnt_reg + 11'd1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_INS_WAIT;
                S_INS_WAIT: state_reg <= S_INS_WR;
                S_INS_WR:
                begin
                    k_reg <= k_reg - 11'd1;
                    state_reg <= S_INS_RD;
                end
                S_DONE:
                    if (!out_v_reg || !out_stall)
                    begin
                        out_v_reg <= 1'b1;
                        out_reg.status <= st_reg;
                        out_reg.block_start <= (st_reg == ST_OK) ? where_reg : 10'd0;
                        out_reg.free_segments <= seg_cnt_reg[6:0];
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_v_reg;
    assign out_word  = out_reg;
endmodule
`default_nettype wire

### tb/segment_allocator_fit_policies_top_tb.sv
// self-checking testbench for the segment allocator top level
// depends on safp_pkg and segment_allocator_fit_policies_top
`timescale 1ns / 1ps
module segment_allocator_fit_policies_top_tb;
    import safp_pkg::*;

    localparam int NSEG = 64;
    localparam int NREC = 63;
    localparam int UMAX = 1024;

    // scoreboard: golden allocator state plus queue of expected result words
    class alloc_scoreboard;
        int unsigned policy;
        int unsigned total;
        int unsigned sstart[NSEG + 1];
        int unsigned slen[NSEG + 1];
        int unsigned scount;
        int unsigned rstart[NREC];
        int unsigned rlen[NREC];
        int unsigned rcount;
        int unsigned rover;
        bit rover_ok;
        out_word_t pending[$];
        int errors;
        int checked;
        int alloc_ok;
        int free_ok;

        function void wipe();
            int unsigned t;
            t = total;
            if (t == 0) t = 1;
            if (t > UMAX) t = UMAX;
            sstart[0] = 0;
            slen[0] = t;
            scount = 1;
            rcount = 0;
            rover = 0;
            rover_ok = 1;
        endfunction

        function void drop_seg(int unsigned i);
            for (int unsigned k = i; k + 1 < scount; k++)
            begin
                sstart[k] = sstart[k + 1];
                slen[k] = slen[k + 1];
            end
            scount--;
        endfunction

        function int pick_seg(int unsigned size);
            int pick;
            int unsigned from;
            int unsigned i;
            pick = -1;
            if (policy == POL_NEXT)
            begin
                if (scount == 0) return -1;
                from = (rover_ok && rover < scount) ? rover : 0;
                for (int unsigned k = 0; k < scount; k++)
                begin
                    i = from + k;
                    if (i >= scount) i -= scount;
                    if (slen[i] >= size) return i;
                end
                return -1;
            end
            for (int unsigned j = 0; j < scount; j++)
            begin
                if (slen[j] < size) continue;
                if (pick < 0) pick = j;
                else if (policy == POL_WORST && slen[j] > slen[pick]) pick = j;
                else if (policy != POL_WORST && slen[j] < slen[pick]) pick = j;
            end
            return pick;
        endfunction

        function logic [2:0] allocate(int unsigned size, output int unsigned at);
            int f;
            int unsigned i;
            at = 0;
            if (rcount >= NREC) return ST_FULL;
            f = pick_seg(size);
            if (f < 0) return ST_NOFIT;
            i = f;
            at = sstart[i];
            rstart[rcount] = sstart[i];
            rlen[rcount] = size;
            rcount++;
            if (policy == POL_NEXT)
            begin
                rover_ok = (i + 1 < scount);
                rover = rover_ok ? i + 1 : 0;
            end
            if (slen[i] == size)
            begin
                drop_seg(i);
                if (rover_ok)
                begin
                    if (rover == i)
                    begin
                        rover = 0;
                        rover_ok = (scount > 0);
                    end
                    else if (rover > i)
                        rover--;
                end
            end
            else
            begin
                sstart[i] += size;
                slen[i] -= size;
            end
            return ST_OK;
        endfunction

        function logic [2:0] release_block(int unsigned size, output int unsigned at);
            int r;
            int unsigned p;
            int unsigned s;
            bit jp;
            bit jn;
            at = 0;
            r = -1;
            for (int k = int'(rcount) - 1; k >= 0; k--)
                if (rlen[k] == size)
                begin
                    r = k;
                    break;
                end
            if (r < 0) return ST_NOREC;
            s = rstart[r];
            p = 0;
            while (p < scount && sstart[p] < s) p++;
            jp = (p > 0) && (sstart[p - 1] + slen[p - 1] == s);
            jn = (p < scount) && (s + size == sstart[p]);
            if (!jp && !jn && scount >= NSEG) return ST_FULL;
            for (int unsigned k = r; k + 1 < rcount; k++)
            begin
                rstart[k] = rstart[k + 1];
                rlen[k] = rlen[k + 1];
            end
            rcount--;
            at = s;
            if (jp && jn)
            begin
                slen[p - 1] += size + slen[p];
                drop_seg(p);
                if (rover_ok && rover >= p) rover--;
            end
            else if (jp)
                slen[p - 1] += size;
            else if (jn)
            begin
                sstart[p] = s;
                slen[p] += size;
            end
            else
            begin
                for (int unsigned k = scount; k > p; k--)
                begin
                    sstart[k] = sstart[k - 1];
                    slen[k] = slen[k - 1];
                end
                sstart[p] = s;
                slen[p] = size;
                scount++;
                if (rover_ok && rover >= p) rover++;
            end
            return ST_OK;
        endfunction

        function new();
            policy = POL_BEST;
            total = TOTAL_RESET;
            errors = 0;
            checked = 0;
            wipe();
        endfunction

        // note an accepted input word and queue its result
        function void note_input(in_word_t w);
            out_word_t e;
            int unsigned at;
            int unsigned size;
            at = 0;
            size = w.request_size;
            e.status = ST_OK;
            if (w.kind == KIND_INIT)
                wipe();
            else if (w.kind == KIND_ALLOC || w.kind == KIND_FREE)
            begin
                if (size == 0 || size > UMAX)
                    e.status = ST_BADSIZE;
                else if (w.kind == KIND_ALLOC)
                    e.status = allocate(size, at);
                else
                    e.status = release_block(size, at);
            end
            if (e.status != ST_OK) at = 0;
            if (e.status == ST_OK && w.kind == KIND_ALLOC) alloc_ok++;
            if (e.status == ST_OK && w.kind == KIND_FREE) free_ok++;
            e.block_start = at[9:0];
            e.free_segments = scount[6:0];
            pending.push_back(e);
        endfunction

        function int live_records();
            return rcount;
        endfunction

        function int rec_size(int unsigned k);
            return rlen[k];
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_data;
    logic out_valid;
    logic out_stall;
    out_word_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    segment_allocator_fit_policies_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    alloc_scoreboard sb = new();

    // idle percentages for each side, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    // long receiver hold-off, counted in the receiver process
    int hold_cycles;
    int sent;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        sb.errors++;
    endtask

    // output side: random stall, checks every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (sb.pending.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                out_word_t e;
                e = sb.pending.pop_front();
                if (out_data.status !== e.status)
                    report_mismatch("status", out_data.status, e.status);
                if (out_data.block_start !== e.block_start)
                    report_mismatch("block_start", out_data.block_start, e.block_start);
                if (out_data.free_segments !== e.free_segments)
                    report_mismatch("free_segments", out_data.free_segments,
                        e.free_segments);
                sb.checked++;
            end
        end
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // apb write: setup cycle then access cycle
    task automatic reg_write(input logic addr, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {addr, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_FIT) sb.policy = value & 3;
        else sb.total = value & 'h7ff;
    endtask

    // wait until every expected word came back, plus slack for the datapath
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // offer one word and hold it until accepted; valid drops when the
    // next word idles or when the sender drains
    task automatic send_word(input logic [1:0] kind, input int unsigned size);
        in_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        w.kind = kind;
        w.request_size = size;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(w);
        sent++;
    endtask

    // mostly sizes that fit the current total, plus freeing live record sizes
    task automatic random_word();
        int unsigned r;
        int unsigned cap;
        r = $urandom_range(99);
        cap = (sb.total > 0 && sb.total <= UMAX) ? sb.total : UMAX;
        if (r < 48)
            send_word(KIND_ALLOC, $urandom_range(1, (cap > 40) ? cap / 6 : cap));
        else if (r < 85 && sb.live_records() > 0)
            send_word(KIND_FREE, sb.rec_size($urandom_range(sb.live_records() - 1)));
        else if (r < 90)
            send_word(KIND_FREE, $urandom_range(1, 30));
        else if (r < 93)
            send_word(KIND_INIT, $urandom_range(2047));
        else if (r < 95)
            send_word(2'd3, $urandom_range(2047));
        else if (r < 97)
            send_word($urandom_range(1), $urandom_range(1) ? 0 : $urandom_range(1025, 2047));
        else
            send_word(KIND_ALLOC, $urandom_range(1, 2047));
    endtask

    task automatic run_phase(input int pol, input int unsigned tot, input int n,
                             input int si, input int ri);
        drain();
        send_idle_pct = 0;
        reg_write(ADDR_FIT, pol);
        reg_write(ADDR_TOTAL, tot);
        send_idle_pct = si;
        recv_idle_pct = ri;
        send_word(KIND_INIT, 0);
        repeat (n) random_word();
    endtask

    initial
    begin
        #20_000_000;
        $display("segment_allocator_fit_policies_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (10) @(posedge clk);

        // directed: reset state, bad sizes, unused kind, fits and merges
        send_word(KIND_ALLOC, 0);
        send_word(KIND_FREE, 1025);
        send_word(KIND_ALLOC, 2047);
        send_word(2'd3, 5);
        send_word(KIND_FREE, 7);
        send_word(KIND_ALLOC, 101);
        send_word(KIND_ALLOC, 10);
        send_word(KIND_ALLOC, 20);
        send_word(KIND_ALLOC, 30);
        send_word(KIND_FREE, 10);
        send_word(KIND_FREE, 30);
        send_word(KIND_FREE, 20);
        send_word(KIND_ALLOC, 100);
        send_word(KIND_ALLOC, 1);
        send_word(KIND_FREE, 100);
        drain();
        reg_write(ADDR_TOTAL, 0);
        reg_write(ADDR_FIT, POL_NEXT);
        send_word(KIND_INIT, 0);
        send_word(KIND_ALLOC, 1);
        send_word(KIND_ALLOC, 1);
        send_word(KIND_FREE, 1);
        drain();
        reg_write(ADDR_TOTAL, 2047);
        send_word(KIND_INIT, 0);
        send_word(KIND_ALLOC, 1024);
        send_word(KIND_FREE, 1024);

        // record table full: many one- or three-unit allocations, then fragment
        drain();
        reg_write(ADDR_FIT, POL_BEST);
        reg_write(ADDR_TOTAL, 1024);
        send_word(KIND_INIT, 0);
        repeat (64) send_word(KIND_ALLOC, 1 + $urandom_range(1) * 2);
        // free random records to fragment the free list
        for (int k = 0; k < 40; k++)
            send_word(KIND_FREE, sb.live_records() > 0 ?
                sb.rec_size($urandom_range(sb.live_records() - 1)) : 1);

        run_phase(POL_BEST, 300, 100, 0, 0);
        run_phase(POL_WORST, 1024, 100, 77, 0);
        run_phase(POL_NEXT, 200, 100, 0, 77);
        run_phase(3, 1, 40, 12, 12);
        run_phase(POL_NEXT, 500, 100, 12, 12);

        // receiver holds off while sender keeps offering
        drain();
        hold_cycles = 3000;
        repeat (60) random_word();
        // sender pauses until every result is back
        drain();
        repeat (100) random_word();

        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("covered %0d words (%0d allocs, %0d frees ok), %0d results checked",
            sent, sb.alloc_ok, sb.free_ok, sb.checked);
        $display("all three fit rules, unused policy, total extremes, full tables");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("segment_allocator_fit_policies_top_tb OK");
        else
            $display("segment_allocator_fit_policies_top_tb NOT OK");
        $finish;
    end
endmodule
